### sv/rem_pkg.sv
// Package for regression_error_metrics: widths, limits, controller state type
// and command/status structs shared by controller and datapath.
// No dependencies.
`default_nettype none
package rem_pkg;
	localparam int unsigned MAX_ITEMS_DEF = 65536;
	localparam int unsigned COUNT_W = 17;
	localparam logic [16:0] COUNT_MAX = 17'h1FFFF;
	localparam int unsigned DIV_W = 56;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PCT,
		ST_SYM,
		ST_ACC,
		ST_MAE,
		ST_MSE,
		ST_MAPE,
		ST_SMAPE,
		ST_SQRT,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		DV_PCT,
		DV_SYM,
		DV_MAE,
		DV_MSE,
		DV_MAPE,
		DV_SMAPE
	} div_sel_t;

	typedef struct packed {
		logic     load;
		logic     div_start;
		div_sel_t div_sel;
		logic     take_pct;
		logic     take_sym;
		logic     acc;
		logic     take_res;
		logic     sqrt_start;
		logic     clear;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic div_busy;
		logic sqrt_busy;
		logic last;
		logic out_full;
		logic out_take;
	} sts_t;
endpackage
`default_nettype wire

### sv/regression_error_metrics.sv
// regression_error_metrics: MAE, MSE, RMSE, MAPE and SMAPE over a stream of
// signed Q8.8 (true, predicted) pairs.
// Slave channel s_axis_*: one pair per item, tlast marks the final pair.
// Master channel m_axis_*: one result item per final pair.
// Each item takes two 33-bit divisions on the one shared radix-2 divider
// (one quotient bit a cycle), an accumulate step and a return to idle.
// A final pair adds four divisions on the same divider, a square root and
// an output load, which waits while a full output register is not taken.
// One item is in work at a time; s_axis_tready is high only while idle.
// The result sits in an output register; while the receiver stalls the
// block may accept and accumulate further pairs, and holds before loading
// the next result.
// Reset clears count, sums and the output valid flag.
// Depends on rem_pkg, rem_ctrl, rem_dp.
`default_nettype none
module regression_error_metrics #(
	parameter int unsigned MAX_ITEMS = rem_pkg::MAX_ITEMS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// [15:0] true_value, [31:16] predicted_value
	input  wire logic [31:0]  s_axis_tdata,
	input  wire logic         s_axis_tlast,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// [15:0] mean_abs_error, [47:16] mean_sq_error, [63:48] root_mean_sq_error,
	// [86:64] mean_abs_pct_error, [102:87] sym_mean_abs_pct_error,
	// [119:103] element_count
	output logic [119:0]      m_axis_tdata
);
	import rem_pkg::*;
	cmd_t cmd;
	sts_t sts;
	logic [119:0] dp_data;

	rem_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready), .sts(sts), .cmd(cmd)
	);
	rem_dp #(.MAX_ITEMS(MAX_ITEMS)) u_dp (
		.clk(clk), .arst_n(arst_n), .true_value(s_axis_tdata[15:0]),
		.predicted_value(s_axis_tdata[31:16]), .last_item(s_axis_tlast),
		.cmd(cmd), .sts(sts), .out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready), .out_data(dp_data)
	);
	assign m_axis_tdata = dp_data;
endmodule
`default_nettype wire

### sv/rem_ctrl.sv
// Controller FSM for regression_error_metrics.
// Depends on rem_pkg.
`default_nettype none
module rem_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire rem_pkg::sts_t sts,
	output rem_pkg::cmd_t      cmd
);
	import rem_pkg::*;
	state_t state_q, state_d;
	logic   go_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			go_q <= 1'b0;
		end else begin
			state_q <= state_d;
			go_q <= (state_d != state_q) || (state_q == ST_IDLE && in_valid);
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_PCT;
			ST_PCT: if (!go_q && !sts.div_busy) state_d = ST_SYM;
			ST_SYM: if (!go_q && !sts.div_busy) state_d = ST_ACC;
			ST_ACC: state_d = sts.last ? ST_MAE : ST_IDLE;
			ST_MAE: if (!go_q && !sts.div_busy) state_d = ST_MSE;
			ST_MSE: if (!go_q && !sts.div_busy) state_d = ST_MAPE;
			ST_MAPE: if (!go_q && !sts.div_busy) state_d = ST_SMAPE;
			ST_SMAPE: if (!go_q && !sts.div_busy) state_d = ST_SQRT;
			ST_SQRT: if (!go_q && !sts.sqrt_busy) state_d = ST_OUT;
			ST_OUT: if (!sts.out_full || sts.out_take) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.div_sel = DV_PCT;
		in_ready = (state_q == ST_IDLE);
		cmd.load = in_ready && in_valid;
		case (state_q)
			ST_PCT: begin
				cmd.div_sel = DV_PCT;
				cmd.div_start = go_q;
				cmd.take_pct = !go_q && !sts.div_busy;
			end
			ST_SYM: begin
				cmd.div_sel = DV_SYM;
				cmd.div_start = go_q;
				cmd.take_sym = !go_q && !sts.div_busy;
			end
			ST_ACC: cmd.acc = 1'b1;
			ST_MAE: begin
				cmd.div_sel = DV_MAE;
				cmd.div_start = go_q;
				cmd.take_res = !go_q && !sts.div_busy;
			end
			ST_MSE: begin
				cmd.div_sel = DV_MSE;
				cmd.div_start = go_q;
				cmd.take_res = !go_q && !sts.div_busy;
			end
			ST_MAPE: begin
				cmd.div_sel = DV_MAPE;
				cmd.div_start = go_q;
				cmd.take_res = !go_q && !sts.div_busy;
			end
			ST_SMAPE: begin
				cmd.div_sel = DV_SMAPE;
				cmd.div_start = go_q;
				cmd.take_res = !go_q && !sts.div_busy;
			end
			ST_SQRT: cmd.sqrt_start = go_q;
			ST_OUT: begin
				cmd.out_load = !sts.out_full || sts.out_take;
				cmd.clear = cmd.out_load;
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

### sv/rem_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, width rem_pkg::DIV_W.
// Depends on rem_pkg.
`default_nettype none
module rem_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [rem_pkg::DIV_W-1:0]  num,
	input  wire logic [rem_pkg::DIV_W-1:0]  den,
	input  wire logic [5:0]                 nbits,
	output logic                            busy,
	output logic [rem_pkg::DIV_W-1:0]       quo
);
	import rem_pkg::*;
	logic [DIV_W-1:0] rem_q, den_q, num_q;
	logic [5:0]       cnt_q;
	logic [DIV_W:0]   trial;

	assign trial = {rem_q, num_q[DIV_W-1]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy <= 1'b1;
			cnt_q <= nbits;
		end else if (busy) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) busy <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			num_q <= num << (7'(DIV_W) - 7'(nbits));
			quo <= '0;
		end else if (busy) begin
			num_q <= num_q << 1;
			if (!trial[DIV_W]) begin
				rem_q <= trial[DIV_W-1:0];
				quo <= {quo[DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DIV_W-2:0], num_q[DIV_W-1]};
				quo <= {quo[DIV_W-2:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

### sv/rem_sqrt.sv
// Iterative 32-bit floor integer square root, two bits per cycle.
// No package dependency.
`default_nettype none
module rem_sqrt (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] val,
	output logic             busy,
	output logic [15:0]      root
);
	logic [31:0] v_q, r_q, b_q;
	logic [31:0] rb;
	assign rb = r_q + b_q;
	assign root = r_q[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) busy <= 1'b0;
		else if (start) busy <= 1'b1;
		else if (busy && b_q[1:0] != 2'b00) busy <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q <= val;
			r_q <= '0;
			b_q <= 32'h4000_0000;
		end else if (busy) begin
			if (v_q >= rb) begin
				v_q <= v_q - rb;
				r_q <= (r_q >> 1) + b_q;
			end else begin
				r_q <= r_q >> 1;
			end
			b_q <= b_q >> 2;
		end
	end
endmodule
`default_nettype wire

### sv/rem_dp.sv
// Datapath: difference, sums, shared divider, square root, output register.
// Depends on rem_pkg, rem_div, rem_sqrt.
`default_nettype none
module rem_dp #(
	parameter int unsigned MAX_ITEMS = rem_pkg::MAX_ITEMS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [15:0]   true_value,
	input  wire logic [15:0]   predicted_value,
	input  wire logic          last_item,
	input  wire rem_pkg::cmd_t cmd,
	output rem_pkg::sts_t      sts,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [119:0]       out_data
);
	import rem_pkg::*;
	localparam logic [16:0] LIMIT =
		(MAX_ITEMS > 131071) ? COUNT_MAX : 17'(MAX_ITEMS);

	logic [16:0] at_q, ap_q, ad_q;
	logic        last_q;
	logic [16:0] cnt_q;
	logic [31:0] abs_q;
	logic [47:0] sq_q;
	logic [39:0] pct_q;
	logic [33:0] sym_q;
	logic [23:0] pr_q;
	logic [16:0] sr_q;
	logic [33:0] sqr_s1;
	logic [15:0] mae_q, rmse_q, smape_q;
	logic [31:0] mse_q;
	logic [22:0] mape_q;
	logic [16:0] n;
	logic [16:0] tdiff, pdiff, dd;
	logic [17:0] sum_ap;
	logic [DIV_W-1:0] num, den, quo;
	logic [5:0]  nbits;
	logic        div_busy, sqrt_busy;
	logic [15:0] root;
	logic [48:0] sq_add;
	logic [40:0] pct_add;
	logic [34:0] sym_add;
	logic [32:0] abs_add;

	assign tdiff = {true_value[15], true_value};
	assign pdiff = {predicted_value[15], predicted_value};
	assign dd = tdiff - pdiff;
	assign n = (cnt_q == '0) ? 17'd1 : cnt_q;
	assign sum_ap = {1'b0, at_q} + {1'b0, ap_q};

	// sums times 100 as 64 + 32 + 4
	always_comb begin
		num = '0;
		den = '0;
		nbits = 6'd33;
		case (cmd.div_sel)
			DV_PCT: begin
				num = DIV_W'({ad_q, 16'h0});
				den = DIV_W'(at_q);
			end
			DV_SYM: begin
				num = DIV_W'({ad_q, 16'h0});
				den = DIV_W'(sum_ap);
			end
			DV_MAE: begin
				num = DIV_W'(abs_q);
				den = DIV_W'(n);
			end
			DV_MSE: begin
				num = DIV_W'(sq_q);
				den = DIV_W'(n);
				nbits = 6'd48;
			end
			DV_MAPE: begin
				num = DIV_W'({pct_q, 6'h0}) + DIV_W'({pct_q, 5'h0}) + DIV_W'({pct_q, 2'h0});
				den = DIV_W'({n, 8'h0});
				nbits = 6'd47;
			end
			DV_SMAPE: begin
				num = DIV_W'({sym_q, 6'h0}) + DIV_W'({sym_q, 5'h0}) + DIV_W'({sym_q, 2'h0});
				den = DIV_W'({n, 7'h0});
				nbits = 6'd41;
			end
			default: ;
		endcase
	end

	rem_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start), .num(num), .den(den),
		.nbits(nbits), .busy(div_busy), .quo(quo)
	);
	rem_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(cmd.sqrt_start), .val(mse_q),
		.busy(sqrt_busy), .root(root)
	);

	assign sts.div_busy = div_busy;
	assign sts.sqrt_busy = sqrt_busy;
	assign sts.last = last_q;
	assign sts.out_full = out_valid;
	assign sts.out_take = out_ready;

	assign abs_add = {1'b0, abs_q} + 33'(ad_q);
	assign sq_add = {1'b0, sq_q} + 49'(sqr_s1);
	assign pct_add = {1'b0, pct_q} + 41'(pr_q);
	assign sym_add = {1'b0, sym_q} + 35'(sr_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			at_q <= tdiff[16] ? -tdiff : tdiff;
			ap_q <= pdiff[16] ? -pdiff : pdiff;
			ad_q <= dd[16] ? -dd : dd;
			last_q <= last_item;
		end
		sqr_s1 <= ad_q * ad_q;
		if (cmd.take_pct)
			pr_q <= (at_q == '0) ? '0 :
				(quo > DIV_W'(24'hFF0000)) ? 24'hFF0000 : quo[23:0];
		if (cmd.take_sym)
			sr_q <= (sum_ap == '0) ? '0 : quo[16:0];
		if (cmd.take_res) begin
			case (cmd.div_sel)
				DV_MAE: mae_q <= (quo > DIV_W'(16'hFFFF)) ? 16'hFFFF : quo[15:0];
				DV_MSE: mse_q <= (quo > DIV_W'(32'hFFFFFFFF)) ? '1 : quo[31:0];
				DV_MAPE: mape_q <= (quo > DIV_W'(23'h7FFFFF)) ? '1 : quo[22:0];
				DV_SMAPE: smape_q <= (quo > DIV_W'(16'hFFFF)) ? '1 : quo[15:0];
				default: ;
			endcase
		end
		rmse_q <= root;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			abs_q <= '0;
			sq_q <= '0;
			pct_q <= '0;
			sym_q <= '0;
		end else if (cmd.clear) begin
			cnt_q <= '0;
			abs_q <= '0;
			sq_q <= '0;
			pct_q <= '0;
			sym_q <= '0;
		end else if (cmd.acc) begin
			if (cnt_q < LIMIT) begin
				cnt_q <= cnt_q + 17'd1;
				abs_q <= abs_add[32] ? '1 : abs_add[31:0];
				sq_q <= sq_add[48] ? '1 : sq_add[47:0];
				pct_q <= pct_add[40] ? '1 : pct_add[39:0];
				sym_q <= sym_add[34] ? '1 : sym_add[33:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (cmd.out_load) out_valid <= 1'b1;
		else if (out_ready) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load)
			out_data <= {cnt_q, smape_q, mape_q, rmse_q, mse_q, mae_q};
	end
endmodule
`default_nettype wire

### sv/rem_chk.sv
// Port-level checker for regression_error_metrics, bound to the top level.
// No package dependency.
`default_nettype none
module rem_chk (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_axis_tvalid,
	input wire logic         s_axis_tready,
	input wire logic         m_axis_tvalid,
	input wire logic         m_axis_tready,
	input wire logic [119:0] m_axis_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped while stalled");
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second item accepted while busy");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[119:103] != 17'd0)
		else $error("result with zero count");
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({s_axis_tready, m_axis_tvalid}))
		else $error("handshake output unknown");
endmodule
bind regression_error_metrics rem_chk u_chk (
	.clk(clk), .arst_n(arst_n), .s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire
